FILE: hdl/ucl_pkg.sv
// ---------------------------------------------------------------------------
// ucl_pkg: shared definitions for the serial command line parser
// Register indexes, reset values, character codes, result kinds, the
// configuration bundle and small character classification helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ucl_pkg;

  // Sizing
  localparam int LINE_BYTES_DEF = 64;
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int RX_W           = 8;
  localparam int POS_W          = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;
  localparam int OUT_DATA_W     = 64;
  localparam int OUT_USER_W     = 2;
  localparam int STEP_W         = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEST_TYPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTIF_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_POS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTIF_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONTENT_POS = 3'd4;

  // Register reset values
  localparam logic [7:0]       RST_TEST_TYPE   = 8'd116;
  localparam logic [7:0]       RST_NOTIF_TYPE  = 8'd115;
  localparam logic [POS_W-1:0] RST_TYPE_POS    = 6'd0;
  localparam logic [POS_W-1:0] RST_NOTIF_LEN   = 6'd14;
  localparam logic [POS_W-1:0] RST_CONTENT_POS = 6'd13;

  // Character codes
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_BS_ALT = 8'd177;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;

  // Result kinds
  localparam logic [OUT_USER_W-1:0] KIND_TEST  = 2'd0;
  localparam logic [OUT_USER_W-1:0] KIND_NOTIF = 2'd1;
  localparam logic [OUT_USER_W-1:0] KIND_ECHO  = 2'd2;

  // Read sequence: type, content, then line indices 1..12
  localparam logic [STEP_W-1:0] STEP_LAST     = 4'd14;
  localparam logic [STEP_W-1:0] P_TYPE        = 4'd0;
  localparam logic [STEP_W-1:0] P_CONTENT     = 4'd1;
  localparam logic [STEP_W-1:0] P_HI_FIRST    = 4'd2;
  localparam logic [STEP_W-1:0] P_HI_LAST     = 4'd9;
  localparam logic [STEP_W-1:0] P_LO_FIRST    = 4'd10;

  typedef struct packed {
    logic [7:0]       test_type;
    logic [7:0]       notif_type;
    logic [POS_W-1:0] type_pos;
    logic [POS_W-1:0] notif_len;
    logic [POS_W-1:0] content_pos;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_backspace(input logic [7:0] c);
    return (c == CH_BS) || (c == CH_DEL) || (c == CH_BS_ALT);
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/uart_command_line_parser_unit.sv
// ---------------------------------------------------------------------------
// uart_command_line_parser_unit: serial command line parser
// Collects alphanumeric bytes into a line and, on carriage return,
// replies to port tests, decodes notifications or echoes unknown types.
//
//   channel   dir  signals                          contents
//   s_axis    in   tvalid tready tdata[7:0]         rx_byte
//   m_axis    out  tvalid tready tuser[1:0]         result_kind
//                  tdata[63:0]                      node_address, notif_content,
//                                                   echoed_type
//   cfg       in   cfg_we_i cfg_idx_i cfg_wdata_i   register writes
//
// An ordinary byte is taken whenever the command queue has room; a carriage return
// on a non-empty line occupies the line processor while it reads the type,
// content and twelve address characters from the line memory one per cycle.
// A four-entry command queue lets bytes keep arriving while a line is
// processed or a result waits on m_axis_tready. No clearing pass after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uart_command_line_parser_unit import ucl_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // rx_byte [7:0]
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [RX_W-1:0]       s_axis_tdata,
  // node_address [47:0], notif_content [55:48], echoed_type [63:56]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // result_kind [1:0]
  output logic [OUT_USER_W-1:0]      m_axis_tuser,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int CntW = $clog2(LINE_BYTES + 1);
  localparam int CmdW = CntW + 9;

  cfg_t            cfg_q;
  logic            cmd_push, cmd_full, cmd_valid, cmd_pop;
  logic [CmdW-1:0] cmd_wdata, cmd_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.test_type   <= RST_TEST_TYPE;
      cfg_q.notif_type  <= RST_NOTIF_TYPE;
      cfg_q.type_pos    <= RST_TYPE_POS;
      cfg_q.notif_len   <= RST_NOTIF_LEN;
      cfg_q.content_pos <= RST_CONTENT_POS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEST_TYPE:   cfg_q.test_type   <= cfg_wdata_i;
        REG_NOTIF_TYPE:  cfg_q.notif_type  <= cfg_wdata_i;
        REG_TYPE_POS:    cfg_q.type_pos    <= cfg_wdata_i[POS_W-1:0];
        REG_NOTIF_LEN:   cfg_q.notif_len   <= cfg_wdata_i[POS_W-1:0];
        REG_CONTENT_POS: cfg_q.content_pos <= cfg_wdata_i[POS_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Intake and classification
  ucl_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .cmd_push_o (cmd_push),
    .cmd_data_o (cmd_wdata),
    .cmd_full_i (cmd_full)
  );

  // Command queue
  ucl_cmd_fifo #(
    .WIDTH(CmdW),
    .DEPTH(CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_wdata),
    .full_o      (cmd_full),
    .valid_o     (cmd_valid),
    .pop_i       (cmd_pop),
    .pop_data_o  (cmd_rdata)
  );

  // Line store and processing
  ucl_back #(
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_data_i  (cmd_rdata),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: hdl/ucl_front.sv
// ---------------------------------------------------------------------------
// ucl_front: byte intake and classification
// Tracks the line length, turns alphanumeric characters into store commands and a
// carriage return on a non-empty line into a line command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucl_front import ucl_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  localparam int CntW = $clog2(LINE_BYTES + 1),
  localparam int CmdW = CntW + 9
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [RX_W-1:0] in_byte_i,
  output logic                 cmd_push_o,
  output logic [CmdW-1:0]      cmd_data_o,
  input  wire logic            cmd_full_i
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            is_line;

  assign in_ready_o = !cmd_full_i;
  assign accept     = in_valid_i && !cmd_full_i;
  // command: {line flag, byte, count}; count is the write index or the length
  assign cmd_data_o = {is_line, in_byte_i, cnt_q};

  // Classify the beat and advance the count
  always_comb begin
    cnt_d      = cnt_q;
    cmd_push_o = 1'b0;
    is_line    = 1'b0;
    if (accept) begin
      priority if (cnt_q == CntW'(LINE_BYTES)) begin
        // full line: drop this byte and restart
        cnt_d = '0;
      end else if (is_alnum(in_byte_i)) begin
        cmd_push_o = 1'b1;
        cnt_d      = cnt_q + CntW'(1);
      end else if (is_backspace(in_byte_i)) begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CntW'(1);
        end
      end else if (in_byte_i == CH_CR) begin
        if (cnt_q != '0) begin
          cmd_push_o = 1'b1;
          is_line    = 1'b1;
        end
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ucl_cmd_fifo.sv
// ---------------------------------------------------------------------------
// ucl_cmd_fifo: command queue between intake and line processing
// Small register queue; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucl_cmd_fifo import ucl_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_FIFO_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LvlW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [LvlW-1:0]  level_q;
  logic             do_push, do_pop;

  assign full_o     = (level_q == LvlW'(DEPTH));
  assign valid_o    = (level_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + LvlW'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - LvlW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ucl_back.sv
// ---------------------------------------------------------------------------
// ucl_back: line store and line processing
// Writes characters into the line memory and, on a line command, reads
// the type, content and twelve address characters one per cycle, parses
// the two hex groups and loads the result register unless a notification has the wrong length.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucl_back import ucl_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  localparam int CntW = $clog2(LINE_BYTES + 1),
  localparam int CmdW = CntW + 9
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_t                  cfg_i,
  input  wire logic                  cmd_valid_i,
  input  wire logic [CmdW-1:0]       cmd_data_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [OUT_USER_W-1:0]      out_kind_o,
  output logic [OUT_DATA_W-1:0]      out_data_o
);

  localparam int AddrW = $clog2(LINE_BYTES);
  localparam int ExtW  = (CntW > POS_W) ? CntW : POS_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_DONE
  } state_e;

  state_e               state_q;
  logic [7:0]           line_mem [LINE_BYTES];
  logic [7:0]           mem_rd_q;
  logic                 rd_ok_q;
  logic [CntW-1:0]      len_q;
  logic [STEP_W-1:0]    step_q;
  logic [7:0]           type_q, content_q;
  logic [31:0]          hi_q, hi_d;
  logic [15:0]          lo_q, lo_d;
  logic                 stop_q, stop_d;
  logic                 zero_q, zero_d;
  logic                 out_valid_q;
  logic [OUT_USER_W-1:0] out_kind_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic                 cmd_is_line;
  logic [7:0]           cmd_byte;
  logic [CntW-1:0]      cmd_cnt;
  logic                 mem_we;
  logic [POS_W-1:0]     rd_pos;
  logic [ExtW-1:0]      rd_pos_ext;
  logic [AddrW-1:0]     rd_addr;
  logic [7:0]           rd_char;
  logic [STEP_W-1:0]    proc_idx, grp_idx;
  logic                 in_hi, in_lo, grp_first;
  hex_t                 hex;
  logic                 is_test, is_notif, len_ok, res_valid, emit;
  logic [OUT_USER_W-1:0] res_kind;
  logic [OUT_DATA_W-1:0] res_data;

  // Unpack the command
  assign cmd_is_line = cmd_data_i[CmdW-1];
  assign cmd_byte    = cmd_data_i[CntW+:8];
  assign cmd_cnt     = cmd_data_i[CntW-1:0];
  assign cmd_pop_o   = (state_q == B_IDLE) && cmd_valid_i;
  assign mem_we      = cmd_pop_o && !cmd_is_line;

  // Select the read position for this step
  always_comb begin
    if (step_q == 4'd0) begin
      rd_pos = cfg_i.type_pos;
    end else if (step_q == 4'd1) begin
      rd_pos = cfg_i.content_pos;
    end else begin
      rd_pos = POS_W'(step_q) - POS_W'(1);
    end
  end

  assign rd_pos_ext = ExtW'(rd_pos);
  assign rd_addr    = rd_pos_ext[AddrW-1:0];

  // Line memory: one write and one read per cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[cmd_cnt[AddrW-1:0]] <= cmd_byte;
    end
    mem_rd_q <= line_mem[rd_addr];
  end

  // Positions at or beyond the line length read as zero
  assign rd_char = rd_ok_q ? mem_rd_q : 8'h00;

  // Hex group parse, one character per cycle
  assign proc_idx  = step_q - 4'd1;
  assign in_hi     = (proc_idx >= P_HI_FIRST) && (proc_idx <= P_HI_LAST);
  assign in_lo     = (proc_idx >= P_LO_FIRST);
  assign grp_idx   = in_hi ? (proc_idx - P_HI_FIRST) : (proc_idx - P_LO_FIRST);
  assign grp_first = (grp_idx == 4'd0);
  assign hex       = hex_digit(rd_char);

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    stop_d = stop_q;
    zero_d = zero_q;
    if (in_hi || in_lo) begin
      if (grp_first) begin
        stop_d = 1'b0;
        zero_d = (rd_char == CH_ZERO);
        if (in_hi) begin
          hi_d = '0;
        end else begin
          lo_d = '0;
        end
      end
      if (!(stop_d)) begin
        if (grp_idx == 4'd1 && zero_q && (rd_char == CH_LX || rd_char == CH_UX)) begin
          // possible 0x prefix: hold, the next character decides
          stop_d = 1'b0;
        end else if (hex.valid) begin
          if (in_hi) begin
            hi_d = {hi_d[27:0], hex.value};
          end else begin
            lo_d = {lo_d[11:0], hex.value};
          end
        end else begin
          stop_d = 1'b1;
        end
      end
    end
  end

  // Classify the finished line
  assign is_test  = (type_q == cfg_i.test_type);
  assign is_notif = (type_q == cfg_i.notif_type);
  assign len_ok   = (ExtW'(len_q) == ExtW'(cfg_i.notif_len));
  assign res_valid = is_test || !is_notif || len_ok;
  assign emit     = (state_q == B_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    res_kind = KIND_ECHO;
    res_data = '0;
    priority if (is_test) begin
      res_kind = KIND_TEST;
    end else if (is_notif) begin
      res_kind = KIND_NOTIF;
      res_data = {8'h00, content_q, hi_q, lo_q};
    end else begin
      res_data = {type_q, 8'h00, 48'h0};
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      len_q       <= '0;
      rd_ok_q     <= 1'b0;
      type_q      <= '0;
      content_q   <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      stop_q      <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= '0;
      out_data_q  <= '0;
    end else begin
      rd_ok_q <= (rd_pos_ext < ExtW'(len_q));
      // Raise valid on a loaded result, drop it once the beat is taken
      if (emit && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (cmd_valid_i && cmd_is_line) begin
            len_q   <= cmd_cnt;
            step_q  <= '0;
            state_q <= B_READ;
          end
        end
        B_READ: begin
          step_q <= step_q + 4'd1;
          if (step_q != 4'd0) begin
            if (proc_idx == P_TYPE) begin
              type_q <= rd_char;
            end
            if (proc_idx == P_CONTENT) begin
              content_q <= rd_char;
            end
            hi_q   <= hi_d;
            lo_q   <= lo_d;
            stop_q <= stop_d;
            zero_q <= zero_d;
          end
          if (step_q == STEP_LAST) begin
            state_q <= B_DONE;
          end
        end
        B_DONE: begin
          if (emit) begin
            if (res_valid) begin
              out_kind_q  <= res_kind;
              out_data_q  <= res_data;
            end
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: tb/uart_command_line_parser_unit_tb.sv
// ---------------------------------------------------------------------------
// uart_command_line_parser_unit_tb: self-checking bench for the line parser
// Streams received bytes into the parser and checks every reply beat
// against a local line model. Covers port tests, notifications with hex
// address groups, echoes, erase handling, full-line drops and register
// settings at their extremes, under several idling patterns on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_command_line_parser_unit_tb;
  import ucl_pkg::*;

  localparam int LINE_DEPTH    = LINE_BYTES_DEF;
  localparam int SETTLE_CYCLES = 200;
  localparam int STUCK_LIMIT   = 3000;
  localparam int PRINT_LIMIT   = 20;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] addr;
    logic [7:0]  content;
    logic [7:0]  echo;
  } parse_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  // rx_byte [7:0]
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [RX_W-1:0]       s_axis_tdata  = '0;
  // node_address [47:0], notif_content [55:48], echoed_type [63:56]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // result_kind [1:0]
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  // Line model state and its copy of the registers
  logic [7:0] line_buf [LINE_DEPTH];
  int         line_len = 0;
  logic [7:0] test_ch     = RST_TEST_TYPE;
  logic [7:0] notif_ch    = RST_NOTIF_TYPE;
  logic [5:0] type_pos    = RST_TYPE_POS;
  logic [5:0] notif_len   = RST_NOTIF_LEN;
  logic [5:0] content_pos = RST_CONTENT_POS;

  logic [7:0]    rx_pending [$];
  parse_result_t parse_expected [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stim_beats     = 0;
  int beats_in       = 0;
  int beats_out      = 0;
  int error_count    = 0;
  int stuck_cycles   = 0;
  int kind_count [3] = '{0, 0, 0};

  uart_command_line_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // Line model
  // ------------------------------------------------------------------
  function automatic bit is_text_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] char_at(input int pos);
    return (pos < LINE_DEPTH) ? line_buf[pos] : 8'h00;
  endfunction

  // Base-16 group: optional 0x prefix when a digit follows, stop at a non-digit
  function automatic logic [63:0] hex_group(input int first, input int len);
    logic [63:0] acc;
    int          k;
    int          d;
    acc = '0;
    k   = 0;
    if (len >= 3 && char_at(first) == CH_ZERO &&
        (char_at(first + 1) == CH_LX || char_at(first + 1) == CH_UX) &&
        hex_nibble(char_at(first + 2)) >= 0)
      k = 2;
    while (k < len) begin
      d = hex_nibble(char_at(first + k));
      if (d < 0) break;
      acc = (acc << 4) | 64'(d);
      k++;
    end
    return acc;
  endfunction

  function automatic void clear_line();
    for (int k = 0; k < LINE_DEPTH; k++) line_buf[k] = 8'h00;
    line_len = 0;
  endfunction

  // Advance the model by one accepted byte and queue any reply it causes
  function automatic void absorb_byte(input logic [7:0] c);
    logic [7:0]    t;
    logic [63:0]   hi;
    logic [63:0]   lo;
    parse_result_t r;
    if (line_len >= LINE_DEPTH) begin
      clear_line();
      return;
    end
    if (is_text_char(c)) begin
      line_buf[line_len] = c;
      line_len++;
      return;
    end
    if (c == CH_BS || c == CH_DEL || c == CH_BS_ALT) begin
      if (line_len > 0) begin
        line_len--;
        line_buf[line_len] = 8'h00;
      end
      return;
    end
    if (c != CH_CR) return;
    if (line_len > 0) begin
      t = char_at(int'(type_pos));
      r = '0;
      if (t == test_ch) begin
        r.kind = KIND_TEST;
        parse_expected.push_back(r);
        kind_count[0]++;
      end else if (t == notif_ch) begin
        if (line_len == int'(notif_len)) begin
          hi        = hex_group(1, 8);
          lo        = hex_group(9, 4);
          r.kind    = KIND_NOTIF;
          r.addr    = {hi[31:0], lo[15:0]};
          r.content = char_at(int'(content_pos));
          parse_expected.push_back(r);
          kind_count[1]++;
        end
      end else begin
        r.kind = KIND_ECHO;
        r.echo = t;
        parse_expected.push_back(r);
        kind_count[2]++;
      end
    end
    clear_line();
  endfunction

  // ------------------------------------------------------------------
  // Driver: feed rx beats from the pending queue
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_byte(s_axis_tdata);
        beats_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= rx_pending.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: compare each reply beat with the oldest expectation
  // ------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < PRINT_LIMIT)
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    parse_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (parse_expected.size() == 0) begin
          report_mismatch("unexpected reply beat", m_axis_tdata, 64'd0);
        end else begin
          want = parse_expected.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch("result_kind", 64'(m_axis_tuser), 64'(want.kind));
          if (m_axis_tdata[47:0] !== want.addr)
            report_mismatch("node_address", 64'(m_axis_tdata[47:0]), 64'(want.addr));
          if (m_axis_tdata[55:48] !== want.content)
            report_mismatch("notif_content", 64'(m_axis_tdata[55:48]), 64'(want.content));
          if (m_axis_tdata[63:56] !== want.echo)
            report_mismatch("echoed_type", 64'(m_axis_tdata[63:56]), 64'(want.echo));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Drop the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[%0t] watchdog: no beat accepted for %0d cycles", $realtime, STUCK_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    stim_beats++;
  endtask

  task automatic queue_text(input string s);
    for (int k = 0; k < s.len(); k++) queue_byte(s[k]);
  endtask

  function automatic logic [7:0] pick_alnum();
    int k;
    k = $urandom_range(61);
    if (k < 10) return 8'("0" + k);
    if (k < 36) return 8'("A" + k - 10);
    return 8'("a" + k - 36);
  endfunction

  function automatic logic [7:0] pick_hex();
    int k;
    k = $urandom_range(21);
    if (k < 10) return 8'("0" + k);
    if (k < 16) return 8'("a" + k - 10);
    return 8'("A" + k - 16);
  endfunction

  function automatic logic [7:0] pick_erase();
    case ($urandom_range(2))
      0:       return CH_BS;
      1:       return CH_DEL;
      default: return CH_BS_ALT;
    endcase
  endfunction

  function automatic logic [7:0] pick_ignored();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (is_text_char(b) || b == CH_BS || b == CH_DEL || b == CH_BS_ALT || b == CH_CR)
      b = 8'($urandom_range(255));
    return b;
  endfunction

  // One random line shaped by the current register setting
  task automatic queue_random_line();
    logic [7:0] body [$];
    int         len;
    int         sel;
    int         k;
    int         hex_end;
    int         edit_rate;
    sel = $urandom_range(99);
    body.delete();
    if (sel < 8) begin
      // raw bytes, mostly ignored
      repeat ($urandom_range(6, 1)) rx_pending.push_back(8'($urandom_range(255)));
      return;
    end
    if (sel < 13) begin
      queue_byte(CH_CR);
      return;
    end
    if (sel < 18) begin
      // fill the store; the next byte is dropped
      repeat (LINE_DEPTH) queue_byte(pick_alnum());
      queue_byte(8'($urandom_range(255)));
      return;
    end
    if (sel < 45) begin
      // notification shape, sometimes one off in length
      len = int'(notif_len);
      if ($urandom_range(7) == 0) len = len + ($urandom_range(1) ? 1 : -1);
      if (len < 1) len = 1;
      if (len > LINE_DEPTH) len = LINE_DEPTH;
      repeat (len) body.push_back(pick_alnum());
      hex_end = (len - 1 < 12) ? len - 1 : 12;
      for (k = 1; k <= hex_end; k++) body[k] = pick_hex();
      if (len > 3 && $urandom_range(3) == 0) begin
        body[1] = CH_ZERO;
        body[2] = $urandom_range(1) ? CH_LX : CH_UX;
      end
      if (len > 11 && $urandom_range(3) == 0) begin
        body[9]  = CH_ZERO;
        body[10] = $urandom_range(1) ? CH_LX : CH_UX;
      end
      if (hex_end > 0 && $urandom_range(4) == 0) body[$urandom_range(hex_end, 1)] = pick_alnum();
      if (int'(type_pos) < len && is_text_char(notif_ch)) body[type_pos] = notif_ch;
    end else if (sel < 65) begin
      // port test shape
      len = int'(type_pos) + 1 + $urandom_range(12);
      if (len > LINE_DEPTH - 1) len = LINE_DEPTH - 1;
      repeat (len) body.push_back(pick_alnum());
      if (int'(type_pos) < len && is_text_char(test_ch)) body[type_pos] = test_ch;
    end else begin
      len = $urandom_range(20, 1);
      repeat (len) body.push_back(pick_alnum());
    end
    // emit with occasional typo-and-erase pairs and stray ignored bytes
    edit_rate = ($urandom_range(4) == 0) ? 4 : 0;
    if (edit_rate != 0) queue_byte(pick_erase());
    for (k = 0; k < body.size(); k++) begin
      if (edit_rate != 0 && $urandom_range(15) < edit_rate) begin
        queue_byte(pick_alnum());
        queue_byte(pick_erase());
      end
      if ($urandom_range(31) == 0) rx_pending.push_back(pick_ignored());
      queue_byte(body[k]);
    end
    queue_byte(CH_CR);
  endtask

  task automatic queue_random_part(input int budget);
    int first;
    int lines;
    first = stim_beats;
    lines = 0;
    while (stim_beats - first < budget || lines < 2) begin
      queue_random_line();
      lines++;
    end
  endtask

  // Hold until every byte is in and every reply is out, then let the parser go quiet
  task automatic settle();
    while (rx_pending.size() != 0 || s_axis_tvalid || parse_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_TEST_TYPE:   test_ch     = val;
      REG_NOTIF_TYPE:  notif_ch    = val;
      REG_TYPE_POS:    type_pos    = val[5:0];
      REG_NOTIF_LEN:   notif_len   = val[5:0];
      REG_CONTENT_POS: content_pos = val[5:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] t_ch, input logic [7:0] n_ch,
                               input logic [5:0] t_pos, input logic [5:0] n_len,
                               input logic [5:0] c_pos);
    write_reg(REG_TEST_TYPE, t_ch);
    write_reg(REG_NOTIF_TYPE, n_ch);
    write_reg(REG_TYPE_POS, {2'b00, t_pos});
    write_reg(REG_NOTIF_LEN, {2'b00, n_len});
    write_reg(REG_CONTENT_POS, {2'b00, c_pos});
  endtask

  // ------------------------------------------------------------------
  // Sequence of phases
  // ------------------------------------------------------------------
  initial begin
    clear_line();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values, no idling, directed lines first
    apply_setting(RST_TEST_TYPE, RST_NOTIF_TYPE, RST_TYPE_POS, RST_NOTIF_LEN,
                  RST_CONTENT_POS);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_text("t");              queue_byte(CH_CR);
    queue_text("s12345678abcdZ"); queue_byte(CH_CR);
    queue_text("s0x1234560xABq"); queue_byte(CH_CR);
    queue_text("s0xG123450x1zK"); queue_byte(CH_CR);
    queue_text("sFFFFFFFFffffA"); queue_byte(CH_CR);
    queue_text("s0000000000009"); queue_byte(CH_CR);
    queue_text("s123");           queue_byte(CH_CR);
    queue_text("s1234567890abcd"); queue_byte(CH_CR);
    queue_text("Hello");          queue_byte(CH_CR);
    queue_byte(CH_CR);
    // erase on an empty line, then erase a whole word, using each code once
    queue_byte(CH_BS); queue_byte(CH_DEL); queue_byte(CH_BS_ALT); queue_byte(CH_CR);
    queue_text("ab"); queue_byte(CH_DEL); queue_byte(CH_BS_ALT); queue_byte(CH_BS);
    queue_text("t"); queue_byte(CH_CR);
    // longest line that still ends normally
    queue_text("t");
    repeat (LINE_DEPTH - 2) queue_byte(pick_alnum());
    queue_byte(CH_CR);
    // full store: the next byte is dropped, a carriage return too
    repeat (LINE_DEPTH) queue_byte("a");
    queue_text("b"); queue_text("t"); queue_byte(CH_CR);
    repeat (LINE_DEPTH) queue_byte("a");
    queue_byte(CH_CR); queue_text("x"); queue_byte(CH_CR);
    // stray bytes around a line
    queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'h20); queue_byte(8'h0A);
    queue_text("z"); queue_byte(8'h80); queue_byte(CH_CR);
    // sender holds until all replies are back
    settle();
    queue_random_part(20);
    settle();

    // Test char 0 at the last position: every non-empty line is a port test
    apply_setting(8'd0, 8'd255, 6'd63, 6'd63, 6'd0);
    send_idle_pct  = 83;
    recv_stall_pct = 0;
    queue_random_part(20);
    settle();

    // Longest notification, content near the end, receiver stalling
    apply_setting(8'd255, "N", 6'd5, 6'd63, 6'd62);
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    queue_random_part(40);
    settle();

    // Equal type chars, zero notification length
    apply_setting("z", "z", 6'd2, 6'd0, 6'd63);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    queue_random_part(30);
    settle();

    // Single-character notifications
    apply_setting("t", "S", 6'd0, 6'd1, 6'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random_part(30);
    settle();

    if (parse_expected.size() != 0)
      report_mismatch("replies never seen", 64'(parse_expected.size()), 64'd0);
    $display("Covered %0d rx bytes and %0d reply beats over five register settings",
             beats_in, beats_out);
    $display("Replies: %0d port test, %0d notification, %0d echo; %0d mismatches",
             kind_count[0], kind_count[1], kind_count[2], error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
